FILE: rtl/core/inverter_fault_protection_unit_assert.svh
// assertion macros for the inverter fault protection unit
// expects clk and arst_n in the scope of each use
`ifndef INVERTER_FAULT_PROTECTION_UNIT_ASSERT_SVH
`define INVERTER_FAULT_PROTECTION_UNIT_ASSERT_SVH

// condition a implies condition b in the same cycle
`define IFPU_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("ifpu assertion failed");

// condition a implies condition b in the next cycle
`define IFPU_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("ifpu assertion failed");

`endif

FILE: rtl/core/ifpu_pkg.sv
// shared types and constants of the inverter fault protection unit
// no dependencies
`timescale 1ns / 1ps

package ifpu_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W  = 15;
	localparam int CNT_W    = 4;
	localparam int FAULT_W  = 5;
	localparam int NPHASE   = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] MAX_DELAY = 4'd14;

	localparam logic [LIMIT_W-1:0] OVERVOLT_RST  = 15'd3750;
	localparam logic [LIMIT_W-1:0] UNDERVOLT_RST = 15'd180;
	localparam logic [LIMIT_W-1:0] DC_CUR_RST    = 15'd200;
	localparam logic [LIMIT_W-1:0] PH_CUR_RST    = 15'd2000;
	localparam logic [CNT_W-1:0]   DELAY_RST     = 4'd3;

	// fault word bit positions
	localparam int FLT_DC_VOLT = 0;
	localparam int FLT_DC_CUR  = 1;
	localparam int FLT_PHASE_A = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERVOLT  = 3'd0,
		REG_UNDERVOLT = 3'd1,
		REG_DC_CUR    = 3'd2,
		REG_PH_CUR    = 3'd3,
		REG_DELAY     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             trip;
		logic [CNT_W-1:0] count;
	} dbnc_status_t;

endpackage

FILE: rtl/core/ifpu_debounce.sv
// one debounce counter with trip detection and saturation
// depends on ifpu_pkg
`timescale 1ns / 1ps

module ifpu_debounce import ifpu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             cond,
	input  logic [CNT_W-1:0] delay,
	output dbnc_status_t     status
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W:0]   count_inc;
	logic             trip;

	assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
	assign trip      = cond && (count_inc > {1'b0, delay});

	always_comb begin
		priority if (!cond) begin
			count_next = '0;
		end else if (trip) begin
			// delay is at most 14, so delay+1 fits
			count_next = delay + CNT_W'(1);
		end else begin
			count_next = count_inc[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

	assign status.trip  = trip;
	assign status.count = count_q;

endmodule

FILE: rtl/core/inverter_fault_protection_unit.sv
// top level of the inverter fault protection unit
// depends on ifpu_pkg, ifpu_debounce and inverter_fault_protection_unit_assert.svh
`timescale 1ns / 1ps
`include "inverter_fault_protection_unit_assert.svh"

// usage
// - s_axis: one sample word per handshake (dc voltage, dc current, three phase
//   currents, run flag); m_axis: one result word per sample (latched fault bits,
//   run flag after protection, captured phase currents)
// - cfg: write channel, cfg_index selects the limit or trip delay register,
//   cfg_data carries the value; always ready, write only while the unit is idle
// - pipeline: input register, then the compare/debounce logic feeding the
//   output register
// - throughput is one word per clock while m_axis does not stall, set by the
//   compare and counter update logic between the input and output registers
// - when m_axis stalls, the output word holds and one more word waits in the
//   input register; s_axis_tready drops only when both are full
// - reset clears counters, fault latch, captured currents and both valid flags
//   and loads the default limits (750 V, 36 V, 10 A, 100 A, delay 3)
// - fault bits stay set until reset

module inverter_fault_protection_unit import ifpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample input
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [15:0] dc_voltage, [31:16] dc_current, [47:32] phase_a_current,
	// [63:48] phase_b_current, [79:64] phase_c_current, [80] run_in, rest zero
	input  logic [87:0]          s_axis_tdata,
	// result output
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [4:0] fault_word, [5] run_out, [21:6] captured_a, [37:22] captured_b,
	// [53:38] captured_c, [55:54] zero
	output logic [55:0]          m_axis_tdata,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	// configuration registers
	logic [LIMIT_W-1:0] overvolt_limit_q;
	logic [LIMIT_W-1:0] undervolt_limit_q;
	logic [LIMIT_W-1:0] dc_current_limit_q;
	logic [LIMIT_W-1:0] phase_current_limit_q;
	logic [CNT_W-1:0]   trip_delay_q;
	logic [CNT_W-1:0]   delay_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overvolt_limit_q      <= OVERVOLT_RST;
			undervolt_limit_q     <= UNDERVOLT_RST;
			dc_current_limit_q    <= DC_CUR_RST;
			phase_current_limit_q <= PH_CUR_RST;
			trip_delay_q          <= DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OVERVOLT:  overvolt_limit_q      <= cfg_data;
				REG_UNDERVOLT: undervolt_limit_q     <= cfg_data;
				REG_DC_CUR:    dc_current_limit_q    <= cfg_data;
				REG_PH_CUR:    phase_current_limit_q <= cfg_data;
				REG_DELAY:     trip_delay_q          <= cfg_data[CNT_W-1:0];
				default:       ; // unknown index, write dropped
			endcase
		end
	end

	// a delay of 15 behaves as 14
	assign delay_eff = (trip_delay_q > MAX_DELAY) ? MAX_DELAY : trip_delay_q;

	// input register stage
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] udc_s1;
	logic signed [SAMPLE_W-1:0] idc_s1;
	logic signed [SAMPLE_W-1:0] ph_s1 [NPHASE];
	logic                       run_s1;
	logic                       advance;
	logic                       m_valid_q;

	// s1 moves into the output register when that register is free or drained
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			udc_s1   <= s_axis_tdata[15:0];
			idc_s1   <= s_axis_tdata[31:16];
			ph_s1[0] <= s_axis_tdata[47:32];
			ph_s1[1] <= s_axis_tdata[63:48];
			ph_s1[2] <= s_axis_tdata[79:64];
			run_s1   <= s_axis_tdata[80];
		end
	end

	// threshold compares, all as 17-bit signed values
	logic signed [SAMPLE_W:0] udc_x;
	logic signed [SAMPLE_W:0] idc_x;
	logic signed [SAMPLE_W:0] ov_lim_x;
	logic signed [SAMPLE_W:0] uv_lim_x;
	logic signed [SAMPLE_W:0] dc_lim_x;
	logic signed [SAMPLE_W:0] ph_lim_x;
	logic signed [SAMPLE_W:0] ph_lim_neg;
	logic                     ov_cond;
	logic                     uv_cond;
	logic                     dc_cond;
	logic [NPHASE-1:0]        ph_cond;

	assign udc_x      = {udc_s1[SAMPLE_W-1], udc_s1};
	assign idc_x      = {idc_s1[SAMPLE_W-1], idc_s1};
	assign ov_lim_x   = {2'b00, overvolt_limit_q};
	assign uv_lim_x   = {2'b00, undervolt_limit_q};
	assign dc_lim_x   = {2'b00, dc_current_limit_q};
	assign ph_lim_x   = {2'b00, phase_current_limit_q};
	assign ph_lim_neg = -ph_lim_x;

	dbnc_status_t ov_st;
	dbnc_status_t uv_st;
	dbnc_status_t dc_st;
	dbnc_status_t ph_st [NPHASE];

	assign ov_cond = udc_x > ov_lim_x;
	// under-voltage only counts while still running after the over-voltage check
	assign uv_cond = (udc_x < uv_lim_x) && run_s1 && !ov_st.trip;
	assign dc_cond = idc_x > dc_lim_x;

	ifpu_debounce u_dbnc_ov (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cond    (ov_cond),
		.delay   (delay_eff),
		.status  (ov_st)
	);

	ifpu_debounce u_dbnc_uv (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cond    (uv_cond),
		.delay   (delay_eff),
		.status  (uv_st)
	);

	ifpu_debounce u_dbnc_dc (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cond    (dc_cond),
		.delay   (delay_eff),
		.status  (dc_st)
	);

	for (genvar p = 0; p < NPHASE; p++) begin : g_phase
		logic signed [SAMPLE_W:0] ph_x;
		assign ph_x       = {ph_s1[p][SAMPLE_W-1], ph_s1[p]};
		assign ph_cond[p] = (ph_x > ph_lim_x) || (ph_x < ph_lim_neg);

		ifpu_debounce u_dbnc_ph (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.cond    (ph_cond[p]),
			.delay   (delay_eff),
			.status  (ph_st[p])
		);
	end

	// fault latch and phase current capture
	logic [FAULT_W-1:0]         fault_q;
	logic [FAULT_W-1:0]         fault_set;
	logic [NPHASE-1:0]          ph_trip;
	logic                       any_trip;
	logic signed [SAMPLE_W-1:0] captured_q [NPHASE];
	logic                       run_out_q;

	always_comb begin
		for (int p = 0; p < NPHASE; p++) begin
			ph_trip[p] = ph_st[p].trip;
		end
		fault_set = '0;
		fault_set[FLT_DC_VOLT] = ov_st.trip || uv_st.trip;
		fault_set[FLT_DC_CUR]  = dc_st.trip;
		fault_set[FLT_PHASE_A +: NPHASE] = ph_trip;
	end

	assign any_trip = |fault_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
			for (int p = 0; p < NPHASE; p++) begin
				captured_q[p] <= '0;
			end
		end else if (advance) begin
			fault_q <= fault_q | fault_set;
			for (int p = 0; p < NPHASE; p++) begin
				if (ph_trip[p]) begin
					captured_q[p] <= ph_s1[p];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_axis_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			run_out_q <= run_s1 && !any_trip;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, captured_q[2], captured_q[1], captured_q[0],
		run_out_q, fault_q};

	// checks
	// latched faults never clear
	`IFPU_ASSERT_NEXT(a_fault_sticky, 1'b1, (fault_q & $past(fault_q)) == $past(fault_q))
	// a trip in a sample leaves the run flag low in its result
	`IFPU_ASSERT_NEXT(a_trip_stops_run, advance && any_trip, m_valid_q && !run_out_q)
	// input stalls only when both registers are full and the output is blocked
	`IFPU_ASSERT_NOW(a_stall_cause, !s_axis_tready, valid_s1 && m_valid_q && !m_axis_tready)
	// a tripping counter settles at delay+1
	`IFPU_ASSERT_NEXT(a_count_sat, advance && ov_st.trip, ov_st.count == delay_eff + CNT_W'(1))

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for inverter_fault_protection_unit
// depends on ifpu_pkg and the unit itself; the expected status words come from a behavioral
// copy of the debounce and trip logic kept inside this file
`timescale 1ns / 1ps

module tb_top;
	import ifpu_pkg::*;

	localparam int SMAX = 32767;
	localparam int SMIN = -32768;

	// register indexes the unit does not decode, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	// sample word as packed on s_axis_tdata, lowest field last
	typedef struct packed {
		logic [6:0]                 pad;
		logic                       run_in;
		logic signed [SAMPLE_W-1:0] phase_c;
		logic signed [SAMPLE_W-1:0] phase_b;
		logic signed [SAMPLE_W-1:0] phase_a;
		logic signed [SAMPLE_W-1:0] dc_current;
		logic signed [SAMPLE_W-1:0] dc_voltage;
	} sample_t;

	// status word as packed on m_axis_tdata
	typedef struct packed {
		logic [1:0]                 pad;
		logic signed [SAMPLE_W-1:0] captured_c;
		logic signed [SAMPLE_W-1:0] captured_b;
		logic signed [SAMPLE_W-1:0] captured_a;
		logic                       run_out;
		logic [FAULT_W-1:0]         fault_word;
	} status_t;

	// shape of each sensor channel in the random stream
	typedef enum logic [1:0] {CH_OK, CH_HIGH, CH_LOW} chan_mode_t;
	// receiver stall patterns
	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_THIRD, RX_RARE} rx_mode_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [87:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [55:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_data = '0;

	inverter_fault_protection_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// protection predictor: limits, debounce counters, fault latch and
	// captured phase currents; limits and counters are plain ints to keep compares signed
	// ------------------------------------------------------------------
	int                 lim_overvolt, lim_undervolt, lim_dc_current, lim_phase, delay_reg;
	int                 cnt_overvolt, cnt_undervolt, cnt_dc_current;
	int                 cnt_phase [NPHASE];
	logic [FAULT_W-1:0] fault_bits;
	logic [SAMPLE_W-1:0] held_current [NPHASE];

	sample_t samples_todo [$];
	status_t status_due [$];
	int      mismatch_count = 0;

	// delay codes above the maximum behave as the maximum
	function automatic int eff_delay();
		return (delay_reg > int'(MAX_DELAY)) ? int'(MAX_DELAY) : delay_reg;
	endfunction

	// advance one debounce counter, true on a tripping sample
	function automatic logic debounce_trips(inout int count, input logic cond);
		int d;
		d = eff_delay();
		if (!cond) begin
			count = 0;
			return 1'b0;
		end
		count = count + 1;
		if (count > d) begin
			count = d + 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic status_t predict_status(sample_t s);
		status_t r;
		logic    run;
		int      udc, idc;
		int      ph [NPHASE];
		run   = s.run_in;
		udc   = $signed(s.dc_voltage);
		idc   = $signed(s.dc_current);
		ph[0] = $signed(s.phase_a);
		ph[1] = $signed(s.phase_b);
		ph[2] = $signed(s.phase_c);
		if (debounce_trips(cnt_overvolt, udc > lim_overvolt)) begin
			run = 1'b0;
			fault_bits[FLT_DC_VOLT] = 1'b1;
		end
		// sees the run flag already cleared by an over-voltage trip
		if (debounce_trips(cnt_undervolt, (udc < lim_undervolt) && run)) begin
			run = 1'b0;
			fault_bits[FLT_DC_VOLT] = 1'b1;
		end
		if (debounce_trips(cnt_dc_current, idc > lim_dc_current)) begin
			run = 1'b0;
			fault_bits[FLT_DC_CUR] = 1'b1;
		end
		for (int i = 0; i < NPHASE; i++) begin
			if (debounce_trips(cnt_phase[i], (ph[i] > lim_phase) || (ph[i] < -lim_phase))) begin
				run = 1'b0;
				fault_bits[FLT_PHASE_A + i] = 1'b1;
				held_current[i] = SAMPLE_W'(ph[i]);
			end
		end
		r.pad        = '0;
		r.fault_word = fault_bits;
		r.run_out    = run;
		r.captured_a = held_current[0];
		r.captured_b = held_current[1];
		r.captured_c = held_current[2];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_sample(int udc, int idc, int pa, int pb, int pc, logic run);
		sample_t s;
		s.pad        = '0;
		s.run_in     = run;
		s.dc_voltage = SAMPLE_W'(udc);
		s.dc_current = SAMPLE_W'(idc);
		s.phase_a    = SAMPLE_W'(pa);
		s.phase_b    = SAMPLE_W'(pb);
		s.phase_c    = SAMPLE_W'(pc);
		samples_todo.push_back(s);
	endfunction

	// strictly above lim unless lim is SMAX, favoring lim+1 and SMAX
	function automatic int pick_above(int lim);
		if (lim >= SMAX)
			return SMAX;
		case ($urandom_range(2))
			0: return lim + 1;
			1: return SMAX;
			default: return lim + 1 + int'($urandom_range(SMAX - lim - 1));
		endcase
	endfunction

	// strictly below lim unless lim is SMIN
	function automatic int pick_below(int lim);
		if (lim <= SMIN)
			return SMIN;
		case ($urandom_range(2))
			0: return lim - 1;
			1: return SMIN;
			default: return SMIN + int'($urandom_range(lim - 1 - SMIN));
		endcase
	endfunction

	// inclusive range, ends favored
	function automatic int pick_between(int lo, int hi);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(hi - lo));
		endcase
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(5))
			0: return 0;
			1: return SMAX;
			2: return int'($urandom_range(SMAX));
			default: return int'($urandom_range(4000));
		endcase
	endfunction

	function automatic int pick_delay();
		case ($urandom_range(4))
			0: return 0;
			1: return int'(MAX_DELAY);
			2: return 15;
			3: return int'($urandom_range(15));
			default: return int'($urandom_range(4));
		endcase
	endfunction

	// channels 0 dc voltage, 1 dc current, 2..4 phases
	chan_mode_t chan_mode [5];
	int         chan_left [5] = '{0, 0, 0, 0, 0};

	// runs of violating or clean samples per channel, lengths around the trip delay,
	// with some pure noise words mixed in
	function automatic void add_random_samples(int n);
		logic [95:0] raw;
		sample_t     s;
		int          v [5];
		int          m;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 8) begin
				raw = {$urandom(), $urandom(), $urandom()};
				s = raw[87:0];
				s.pad = '0;
				samples_todo.push_back(s);
				continue;
			end
			for (int c = 0; c < 5; c++) begin
				if (chan_left[c] == 0) begin
					m = $urandom_range(3);
					chan_mode[c] = (m == 0) ? CH_HIGH : (m == 1) ? CH_LOW : CH_OK;
					chan_left[c] = $urandom_range(eff_delay() + 3, 1);
				end
				chan_left[c]--;
			end
			case (chan_mode[0])
				CH_HIGH: v[0] = pick_above(lim_overvolt);
				CH_LOW:  v[0] = pick_below(lim_undervolt);
				default: v[0] = (lim_undervolt <= lim_overvolt) ?
					pick_between(lim_undervolt, lim_overvolt) : pick_between(SMIN, SMAX);
			endcase
			v[1] = (chan_mode[1] == CH_HIGH) ? pick_above(lim_dc_current) :
				pick_between(SMIN, lim_dc_current);
			for (int c = 2; c < 5; c++) begin
				case (chan_mode[c])
					CH_HIGH: v[c] = pick_above(lim_phase);
					CH_LOW:  v[c] = pick_below(-lim_phase);
					default: v[c] = pick_between(-lim_phase, lim_phase);
				endcase
			end
			add_sample(v[0], v[1], v[2], v[3], v[4], $urandom_range(9) != 0);
		end
	endfunction

	// one register write through the config channel, predictor follows
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_OVERVOLT:  lim_overvolt   = val;
			REG_UNDERVOLT: lim_undervolt  = val;
			REG_DC_CUR:    lim_dc_current = val;
			REG_PH_CUR:    lim_phase      = val;
			REG_DELAY:     delay_reg      = val[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// wait until every sample went in and every status word came back, then
	// let the two-stage pipe settle
	task automatic drain();
		while (samples_todo.size() != 0 || s_axis_tvalid || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// sample driver: bursts of random length, random gaps in between,
	// some bursts run back to back with no gap at all
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// word taken at this edge, predict its status now
			if (s_axis_tvalid && s_axis_tready)
				status_due.push_back(predict_status(sample_t'(s_axis_tdata)));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || samples_todo.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata  <= samples_todo.pop_front();
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(24, 1);
						gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 1);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// status receiver: switches at random between stall patterns
	// ------------------------------------------------------------------
	rx_mode_t rx_mode  = RX_ALWAYS;
	int       rx_left  = 0;
	int       rx_tick  = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(3));
			rx_left = $urandom_range(120, 20);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= 1'($urandom_range(1));
			RX_THIRD:  m_axis_tready <= (rx_tick % 3 == 0);
			default:   m_axis_tready <= (rx_tick % 8 == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// status monitor: every word taken is checked against the oldest prediction
	// ------------------------------------------------------------------
	status_t mon_got, mon_want;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got = status_t'(m_axis_tdata);
			if (status_due.size() == 0) begin
				$error("status word with no sample pending: %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				mon_want = status_due.pop_front();
				if (mon_got.fault_word !== mon_want.fault_word) begin
					$error("fault_word expected %0d got %0d", mon_want.fault_word,
						mon_got.fault_word);
					mismatch_count++;
				end
				if (mon_got.run_out !== mon_want.run_out) begin
					$error("run_out expected %0d got %0d", mon_want.run_out, mon_got.run_out);
					mismatch_count++;
				end
				if (mon_got.captured_a !== mon_want.captured_a) begin
					$error("captured_a expected %0d got %0d", mon_want.captured_a,
						mon_got.captured_a);
					mismatch_count++;
				end
				if (mon_got.captured_b !== mon_want.captured_b) begin
					$error("captured_b expected %0d got %0d", mon_want.captured_b,
						mon_got.captured_b);
					mismatch_count++;
				end
				if (mon_got.captured_c !== mon_want.captured_c) begin
					$error("captured_c expected %0d got %0d", mon_want.captured_c,
						mon_got.captured_c);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int pa_seq [5];

		pa_seq = '{-2001, SMIN, -3000, SMIN, -2001};

		// predictor state after reset
		lim_overvolt   = OVERVOLT_RST;
		lim_undervolt  = UNDERVOLT_RST;
		lim_dc_current = DC_CUR_RST;
		lim_phase      = PH_CUR_RST;
		delay_reg      = DELAY_RST;
		cnt_overvolt   = 0;
		cnt_undervolt  = 0;
		cnt_dc_current = 0;
		fault_bits     = '0;
		for (int i = 0; i < NPHASE; i++) begin
			cnt_phase[i]    = 0;
			held_current[i] = '0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default limits, delay 3
		add_sample(2000, 0, 0, 0, 0, 1'b1);
		add_sample(2000, 0, 0, 0, 0, 1'b0);
		// under-voltage while stopped is not counted
		repeat (3) add_sample(0, 0, 0, 0, 0, 1'b0);
		// under-voltage while running trips on the fourth sample
		repeat (4) add_sample(SMIN, 0, 0, 0, 0, 1'b1);
		// dc over-current, phases sitting exactly on the limit do not count
		repeat (4) add_sample(2000, SMAX, 2000, -2000, 0, 1'b1);
		// phase a trips twice in a row, capture follows the latest sample
		foreach (pa_seq[i]) add_sample(2000, 0, pa_seq[i], 0, 0, 1'b1);
		// phase b, then phase c with a clean sample breaking its first run
		repeat (4) add_sample(2000, SMIN, 0, SMAX, 0, 1'b1);
		add_sample(2000, 0, 0, 0, -2001, 1'b1);
		add_sample(2000, 0, 0, 0, 0, 1'b1);
		repeat (4) add_sample(2000, 0, 0, 0, 2001, 1'b1);
		// over-voltage at full scale
		repeat (4) add_sample(SMAX, 0, 0, 0, 0, 1'b1);
		drain();

		// crossed voltage limits, delay 0: an over-voltage trip masks the under-voltage count
		write_reg(REG_OVERVOLT, 15'd100);
		write_reg(REG_UNDERVOLT, 15'd200);
		write_reg(REG_DELAY, 15'd0);
		// undecoded index, must change nothing
		write_reg(REG_SPARE_LAST, 15'd0);
		repeat (3) add_sample(150, 0, 0, 0, 0, 1'b1);
		add_sample(50, 0, 0, 0, 0, 1'b1);
		add_sample(150, 0, 0, 0, 0, 1'b0);
		add_sample(50, 201, 0, 0, 0, 1'b1);
		drain();

		// all limits zero, delay code 15 acts as 14
		write_reg(REG_OVERVOLT, 15'd0);
		write_reg(REG_UNDERVOLT, 15'd0);
		write_reg(REG_DC_CUR, 15'd0);
		write_reg(REG_PH_CUR, 15'd0);
		write_reg(REG_DELAY, 15'h7fff);
		repeat (17) add_sample(1, 1, 1, -1, 0, 1'b1);
		repeat (2) add_sample(0, 0, 0, 0, 0, 1'b1);
		drain();

		// random phases, first two pinned to the extremes
		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				write_reg(REG_OVERVOLT, 15'h7fff);
				write_reg(REG_UNDERVOLT, 15'h7fff);
				write_reg(REG_DC_CUR, 15'h7fff);
				write_reg(REG_PH_CUR, 15'h7fff);
				write_reg(REG_DELAY, LIMIT_W'(MAX_DELAY));
			end else if (p == 1) begin
				write_reg(REG_OVERVOLT, 15'd0);
				write_reg(REG_UNDERVOLT, 15'd0);
				write_reg(REG_DC_CUR, 15'd0);
				write_reg(REG_PH_CUR, 15'd0);
				write_reg(REG_DELAY, 15'd0);
			end else begin
				write_reg(REG_OVERVOLT, LIMIT_W'(pick_limit()));
				write_reg(REG_UNDERVOLT, LIMIT_W'(pick_limit()));
				write_reg(REG_DC_CUR, LIMIT_W'(pick_limit()));
				write_reg(REG_PH_CUR, LIMIT_W'(pick_limit()));
				write_reg(REG_DELAY, LIMIT_W'(pick_delay()));
			end
			if ($urandom_range(1))
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
					LIMIT_W'($urandom()));
			add_random_samples(108);
			drain();
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ifpu_pkg.sv
rtl/core/ifpu_debounce.sv
rtl/core/inverter_fault_protection_unit.sv
verif/tb_top.sv
